>>> rtl/clt_pkg.sv
// ============================================================================
// clt_pkg
// Shared types, character codes and defaults of the command line tokenizer.
// ============================================================================
package clt_pkg;

    localparam int TOKEN_CHARS_DEF = 32;
    localparam int MAX_ARGS_DEF    = 16;

    // widest token length over the parameter range
    localparam int LEN_W = 6;

    localparam logic [7:0] NUL_CODE     = 8'd0;
    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] SPACE_CODE   = 8'd32;
    localparam logic [7:0] QUOTE_CODE   = 8'd34;
    localparam logic [7:0] SLASH_CODE   = 8'd47;

    typedef enum logic [2:0] {
        MODE_BETWEEN,
        MODE_AFTER_COMMENT,
        MODE_SLASH,
        MODE_COMMENT,
        MODE_WORD,
        MODE_QUOTED
    } scan_mode_t;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_END   = 2'd2
    } result_kind_t;

    typedef enum logic {
        PH_TOKEN,
        PH_END
    } back_phase_t;

    typedef struct packed {
        logic             has_tok;
        logic [LEN_W-1:0] tok_len;
        logic [3:0]       arg_index;
        logic             has_end;
        logic [4:0]       arg_count;
        logic             bank;
    } run_cmd_t;

endpackage

>>> rtl/command_line_tokenizer_unit.sv
// ============================================================================
// command_line_tokenizer_unit
// Streaming command line tokenizer: text items in, token result items out.
// ============================================================================
// Text is taken one byte per cycle by the scanner while the run queue has
// room; each byte that finishes one of the first MAX_ARGS tokens or a command
// queues one run. The emitter drives one result item per cycle, unless the
// sink stalls, from its single token store read port: one per kept token byte
// (one for an empty token) plus one for end of command. The scanner stalls
// only while two finished runs wait. Token bytes live in a double-buffered
// store of 2 * TOKEN_CHARS bytes, one bank filled while the other is read
// out; no clearing pass after reset.
// ============================================================================
module command_line_tokenizer_unit #(
    parameter int TOKEN_CHARS = clt_pkg::TOKEN_CHARS_DEF,
    parameter int MAX_ARGS    = clt_pkg::MAX_ARGS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] token_byte, [11:8] arg_index, [16:12] arg_count
    output logic        m_tlast,
    output logic [1:0]  m_tuser    // [1:0] result_kind
);

    localparam int DEPTH = 2 * TOKEN_CHARS;
    localparam int AW    = $clog2(DEPTH);

    logic              push, pop, full, head_valid;
    clt_pkg::run_cmd_t push_cmd, head_cmd;
    logic              wr_en, rd_en;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic [7:0]        wr_data, rd_data;
    logic [7:0]        out_byte;
    logic [3:0]        out_index;
    logic [4:0]        out_count;

    clt_front #(
        .TOKEN_CHARS (TOKEN_CHARS),
        .MAX_ARGS    (MAX_ARGS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .queue_full (full),
        .push       (push),
        .push_cmd   (push_cmd),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    clt_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    clt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .head_cmd   (head_cmd),
        .head_valid (head_valid),
        .full       (full)
    );

    clt_back #(
        .TOKEN_CHARS (TOKEN_CHARS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_kind     (m_tuser),
        .m_byte     (out_byte),
        .m_index    (out_index),
        .m_count    (out_count),
        .m_last     (m_tlast)
    );

    assign m_tdata = {7'd0, out_count, out_index, out_byte};

endmodule

>>> rtl/clt_ram.sv
// ============================================================================
// clt_ram
// Generic single write port, single read port RAM with registered read.
// ============================================================================
module clt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/clt_front.sv
// ============================================================================
// clt_front
// Scanner: classify each text item, store token bytes, queue finished runs.
// ============================================================================
module clt_front #(
    parameter int TOKEN_CHARS = clt_pkg::TOKEN_CHARS_DEF,
    parameter int MAX_ARGS    = clt_pkg::MAX_ARGS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [7:0]                         in_byte,
    input  logic                               queue_full,
    output logic                               push,
    output clt_pkg::run_cmd_t                  push_cmd,
    output logic                               wr_en,
    output logic [$clog2(2*TOKEN_CHARS)-1:0]   wr_addr,
    output logic [7:0]                         wr_data
);

    localparam int LW = $clog2(TOKEN_CHARS + 1);
    localparam int PW = $clog2(TOKEN_CHARS);
    localparam int CW = $clog2(MAX_ARGS + 1);
    localparam int AW = $clog2(2 * TOKEN_CHARS);

    clt_pkg::scan_mode_t mode_reg, mode_next;
    logic [LW-1:0]       tok_len_reg, tok_len_next;
    logic [CW-1:0]       arg_cnt_reg, arg_cnt_next;
    logic                bank_reg;

    logic          accept;
    logic          is_nul, is_nl, is_sep, is_slash, is_quote;
    logic [LW-1:0] len_w;
    logic [LW-1:0] flush_len;
    logic [PW-1:0] app_pos;
    logic [7:0]    app_byte;
    logic          do_flush, flush_word, do_end, do_append;
    logic          has_tok;
    logic [CW-1:0] cnt_after;

    assign in_ready = !queue_full;
    assign accept   = in_valid && !queue_full;

    assign is_nul   = (in_byte == clt_pkg::NUL_CODE);
    assign is_nl    = (in_byte == clt_pkg::NEWLINE_CODE);
    assign is_sep   = (in_byte <= clt_pkg::SPACE_CODE);
    assign is_slash = (in_byte == clt_pkg::SLASH_CODE);
    assign is_quote = (in_byte == clt_pkg::QUOTE_CODE);

    assign len_w = (mode_reg == clt_pkg::MODE_SLASH) ? LW'(1) : tok_len_reg;

    always_comb begin
        mode_next = mode_reg;
        unique case (mode_reg) inside
            clt_pkg::MODE_BETWEEN, clt_pkg::MODE_AFTER_COMMENT: begin
                if (is_nul || (is_nl && mode_reg == clt_pkg::MODE_BETWEEN)) begin
                    mode_next = clt_pkg::MODE_BETWEEN;
                end else if (is_sep) begin
                    mode_next = mode_reg;
                end else if (is_slash) begin
                    mode_next = clt_pkg::MODE_SLASH;
                end else if (is_quote) begin
                    mode_next = clt_pkg::MODE_QUOTED;
                end else begin
                    mode_next = clt_pkg::MODE_WORD;
                end
            end
            clt_pkg::MODE_SLASH: begin
                if (is_slash) begin
                    mode_next = clt_pkg::MODE_COMMENT;
                end else if (is_sep) begin
                    mode_next = clt_pkg::MODE_BETWEEN;
                end else begin
                    mode_next = clt_pkg::MODE_WORD;
                end
            end
            clt_pkg::MODE_WORD: begin
                mode_next = is_sep ? clt_pkg::MODE_BETWEEN : clt_pkg::MODE_WORD;
            end
            clt_pkg::MODE_COMMENT: begin
                if (is_nul) begin
                    mode_next = clt_pkg::MODE_BETWEEN;
                end else if (is_nl) begin
                    mode_next = clt_pkg::MODE_AFTER_COMMENT;
                end
            end
            clt_pkg::MODE_QUOTED: begin
                if (is_quote || is_nul) begin
                    mode_next = clt_pkg::MODE_BETWEEN;
                end
            end
            default: mode_next = clt_pkg::MODE_BETWEEN;
        endcase
    end

    always_comb begin
        do_flush     = 1'b0;
        flush_word   = 1'b0;
        do_end       = 1'b0;
        do_append    = 1'b0;
        app_pos      = len_w[PW-1:0];
        app_byte     = in_byte;
        tok_len_next = tok_len_reg;
        unique case (mode_reg) inside
            clt_pkg::MODE_BETWEEN, clt_pkg::MODE_AFTER_COMMENT: begin
                if (is_nul || (is_nl && mode_reg == clt_pkg::MODE_BETWEEN)) begin
                    do_end = 1'b1;
                end else if (is_sep) begin
                    do_end = 1'b0;
                end else if (is_slash) begin
                    // stage the slash in case a word follows
                    do_append = 1'b1;
                    app_pos   = '0;
                    app_byte  = clt_pkg::SLASH_CODE;
                end else if (is_quote) begin
                    tok_len_next = '0;
                end else begin
                    do_append    = 1'b1;
                    app_pos      = '0;
                    tok_len_next = LW'(1);
                end
            end
            clt_pkg::MODE_SLASH, clt_pkg::MODE_WORD: begin
                if (mode_reg == clt_pkg::MODE_SLASH && is_slash) begin
                    do_append = 1'b0;
                end else if (!is_sep) begin
                    tok_len_next = len_w;
                    if (len_w < LW'(TOKEN_CHARS)) begin
                        do_append    = 1'b1;
                        tok_len_next = len_w + LW'(1);
                    end
                end else begin
                    do_flush     = 1'b1;
                    flush_word   = 1'b1;
                    do_end       = is_nul || is_nl;
                    tok_len_next = '0;
                end
            end
            clt_pkg::MODE_COMMENT: begin
                do_end = is_nul;
            end
            clt_pkg::MODE_QUOTED: begin
                if (is_quote || is_nul) begin
                    do_flush     = 1'b1;
                    do_end       = is_nul;
                    tok_len_next = '0;
                end else if (len_w < LW'(TOKEN_CHARS)) begin
                    do_append    = 1'b1;
                    tok_len_next = len_w + LW'(1);
                end
            end
            default: do_end = 1'b0;
        endcase
    end

    assign flush_len = (flush_word && len_w >= LW'(TOKEN_CHARS)) ? '0 : len_w;
    assign has_tok   = do_flush && (arg_cnt_reg < CW'(MAX_ARGS));
    assign cnt_after = arg_cnt_reg + CW'(has_tok);

    assign arg_cnt_next = do_end ? '0 : cnt_after;

    assign push               = accept && (has_tok || do_end);
    assign push_cmd.has_tok   = has_tok;
    assign push_cmd.tok_len   = clt_pkg::LEN_W'(flush_len);
    assign push_cmd.arg_index = 4'(arg_cnt_reg);
    assign push_cmd.has_end   = do_end;
    assign push_cmd.arg_count = 5'(cnt_after);
    assign push_cmd.bank      = bank_reg;

    assign wr_en   = accept && do_append;
    assign wr_addr = AW'(app_pos) + (bank_reg ? AW'(TOKEN_CHARS) : AW'(0));
    assign wr_data = app_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= clt_pkg::MODE_BETWEEN;
            tok_len_reg <= '0;
            arg_cnt_reg <= '0;
            bank_reg    <= 1'b0;
        end else if (accept) begin
            mode_reg    <= mode_next;
            tok_len_reg <= tok_len_next;
            arg_cnt_reg <= arg_cnt_next;
            if (push) begin
                bank_reg <= !bank_reg;
            end
        end
    end

endmodule

>>> rtl/clt_queue.sv
// ============================================================================
// clt_queue
// Two-entry queue of finished runs between scanner and emitter.
// ============================================================================
module clt_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  clt_pkg::run_cmd_t push_cmd,
    input  logic              pop,
    output clt_pkg::run_cmd_t head_cmd,
    output logic              head_valid,
    output logic              full
);

    clt_pkg::run_cmd_t entry_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg, count_next;

    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign head_valid = (count_reg != 2'd0);
    assign full       = (count_reg == 2'd2);

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("run pushed into full queue");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("run popped from empty queue");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("queue count out of range");

endmodule

>>> rtl/clt_back.sv
// ============================================================================
// clt_back
// Emitter: expand each queued run into result items from the token store.
// ============================================================================
module clt_back #(
    parameter int TOKEN_CHARS = clt_pkg::TOKEN_CHARS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               head_valid,
    input  clt_pkg::run_cmd_t                  head_cmd,
    output logic                               pop,
    output logic                               rd_en,
    output logic [$clog2(2*TOKEN_CHARS)-1:0]   rd_addr,
    input  logic [7:0]                         rd_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [1:0]                         m_kind,
    output logic [7:0]                         m_byte,
    output logic [3:0]                         m_index,
    output logic [4:0]                         m_count,
    output logic                               m_last
);

    localparam int PW = $clog2(TOKEN_CHARS);
    localparam int AW = $clog2(2 * TOKEN_CHARS);

    clt_pkg::back_phase_t  phase_reg, phase_next;
    logic [PW-1:0]         pos_reg, pos_next;
    logic                  m_valid_reg, m_valid_next;
    clt_pkg::result_kind_t kind_reg, kind_next;
    logic [3:0]            index_reg, index_next;
    logic [4:0]            count_reg, count_next;
    logic                  last_reg, last_next;

    logic issue, in_tok, tok_empty, tok_done;

    assign issue     = head_valid && (!m_valid_reg || m_ready);
    assign in_tok    = (phase_reg == clt_pkg::PH_TOKEN) && head_cmd.has_tok;
    assign tok_empty = (head_cmd.tok_len == '0);
    assign tok_done  = tok_empty ||
                       (clt_pkg::LEN_W'(pos_reg) + clt_pkg::LEN_W'(1) == head_cmd.tok_len);

    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        pop        = 1'b0;
        if (issue) begin
            if (in_tok) begin
                if (tok_done) begin
                    pos_next = '0;
                    if (head_cmd.has_end) begin
                        phase_next = clt_pkg::PH_END;
                    end else begin
                        pop = 1'b1;
                    end
                end else begin
                    pos_next = pos_reg + PW'(1);
                end
            end else begin
                phase_next = clt_pkg::PH_TOKEN;
                pop        = 1'b1;
            end
        end
    end

    always_comb begin
        kind_next  = kind_reg;
        index_next = index_reg;
        count_next = count_reg;
        last_next  = last_reg;
        rd_en      = 1'b0;
        rd_addr    = AW'(pos_reg) + (head_cmd.bank ? AW'(TOKEN_CHARS) : AW'(0));
        if (issue) begin
            if (in_tok) begin
                kind_next  = tok_empty ? clt_pkg::KIND_EMPTY : clt_pkg::KIND_BYTE;
                index_next = head_cmd.arg_index;
                count_next = '0;
                last_next  = tok_done && !head_cmd.has_end;
                rd_en      = !tok_empty;
            end else begin
                kind_next  = clt_pkg::KIND_END;
                index_next = '0;
                count_next = head_cmd.arg_count;
                last_next  = 1'b1;
            end
        end
    end

    assign m_valid_next = issue ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (issue) begin
            kind_reg  <= kind_next;
            index_reg <= index_next;
            count_reg <= count_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= clt_pkg::PH_TOKEN;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_kind  = kind_reg;
    assign m_byte  = (kind_reg == clt_pkg::KIND_BYTE) ? rd_data : 8'd0;
    assign m_index = index_reg;
    assign m_count = count_reg;
    assign m_last  = last_reg;

    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && kind_reg == clt_pkg::KIND_END |-> last_reg)
        else $error("end of command not marked last");

    a_pos_in_token: assert property (@(posedge aclk) disable iff (!aresetn)
        issue && in_tok && !tok_empty |-> clt_pkg::LEN_W'(pos_reg) < head_cmd.tok_len)
        else $error("read past token length");

    a_pop_shows_last: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> m_valid_reg && last_reg)
        else $error("run retired without last item");

endmodule

>>> tb/sv/tb.sv
// ============================================================================
// tb
// Self-checking bench for command_line_tokenizer_unit: text bytes are streamed
// in under random source gaps and sink stalls, a scoreboard tracks the scan
// state of each byte and queues the token, empty-token and end-of-command
// items it must produce, and every output item is compared field by field.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOKEN_CHARS = clt_pkg::TOKEN_CHARS_DEF;
    localparam int MAX_ARGS    = clt_pkg::MAX_ARGS_DEF;

    typedef struct {
        clt_pkg::result_kind_t kind;
        logic [7:0]            tok;
        logic [3:0]            idx;
        logic [4:0]            cnt;
        logic                  last;
    } token_result_t;

    class tokenizer_scoreboard;
        clt_pkg::scan_mode_t mode;
        logic [7:0]          store [TOKEN_CHARS];
        int unsigned         tok_len;
        int unsigned         args;
        token_result_t       byte_results[$];
        token_result_t       pending_results[$];
        int                  errors;

        function new();
            mode    = clt_pkg::MODE_BETWEEN;
            tok_len = 0;
            args    = 0;
            errors  = 0;
        endfunction

        function void emit(clt_pkg::result_kind_t kind, logic [7:0] tok, int unsigned idx,
                           int unsigned cnt);
            token_result_t r;
            r.kind = kind;
            r.tok  = tok;
            r.idx  = 4'(idx);
            r.cnt  = 5'(cnt);
            r.last = 1'b0;
            byte_results.push_back(r);
        endfunction

        function void append_char(logic [7:0] b);
            if (tok_len < TOKEN_CHARS) begin
                store[tok_len] = b;
                tok_len++;
            end
        endfunction

        function void close_command();
            emit(clt_pkg::KIND_END, 8'd0, 0, args);
            args = 0;
            mode = clt_pkg::MODE_BETWEEN;
        endfunction

        function void close_token(bit is_word);
            int unsigned len;
            len = tok_len;
            if (is_word && len >= TOKEN_CHARS)
                len = 0;
            if (args < MAX_ARGS) begin
                if (len == 0) begin
                    emit(clt_pkg::KIND_EMPTY, 8'd0, args, 0);
                end else begin
                    for (int i = 0; i < len; i++)
                        emit(clt_pkg::KIND_BYTE, store[i], args, 0);
                end
                args++;
            end
            tok_len = 0;
            mode    = clt_pkg::MODE_BETWEEN;
        endfunction

        function void start_token(logic [7:0] b, bit newline_ends);
            if (b == clt_pkg::NUL_CODE || (b == clt_pkg::NEWLINE_CODE && newline_ends)) begin
                close_command();
            end else if (b == clt_pkg::SLASH_CODE) begin
                mode = clt_pkg::MODE_SLASH;
            end else if (b == clt_pkg::QUOTE_CODE) begin
                tok_len = 0;
                mode    = clt_pkg::MODE_QUOTED;
            end else if (b > clt_pkg::SPACE_CODE) begin
                tok_len = 0;
                append_char(b);
                mode = clt_pkg::MODE_WORD;
            end
        endfunction

        function void extend_word(logic [7:0] b);
            if (b > clt_pkg::SPACE_CODE) begin
                append_char(b);
            end else begin
                close_token(1'b1);
                start_token(b, 1'b1);
            end
        endfunction

        function void scan_text_byte(logic [7:0] b);
            token_result_t r;
            byte_results.delete();
            case (mode)
                clt_pkg::MODE_AFTER_COMMENT: begin
                    start_token(b, 1'b0);
                end
                clt_pkg::MODE_SLASH: begin
                    if (b == clt_pkg::SLASH_CODE) begin
                        mode = clt_pkg::MODE_COMMENT;
                    end else begin
                        tok_len = 0;
                        append_char(clt_pkg::SLASH_CODE);
                        mode = clt_pkg::MODE_WORD;
                        extend_word(b);
                    end
                end
                clt_pkg::MODE_COMMENT: begin
                    if (b == clt_pkg::NUL_CODE)
                        close_command();
                    else if (b == clt_pkg::NEWLINE_CODE)
                        mode = clt_pkg::MODE_AFTER_COMMENT;
                end
                clt_pkg::MODE_WORD: begin
                    extend_word(b);
                end
                clt_pkg::MODE_QUOTED: begin
                    if (b == clt_pkg::QUOTE_CODE) begin
                        close_token(1'b0);
                    end else if (b == clt_pkg::NUL_CODE) begin
                        close_token(1'b0);
                        close_command();
                    end else begin
                        append_char(b);
                    end
                end
                default: begin
                    mode = clt_pkg::MODE_BETWEEN;
                    start_token(b, 1'b1);
                end
            endcase
            if (byte_results.size() > 0) begin
                r = byte_results.pop_back();
                r.last = 1'b1;
                byte_results.push_back(r);
            end
            foreach (byte_results[i])
                pending_results.push_back(byte_results[i]);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 100)
                $display("ERROR at %0t: %s", $time, msg);
        endtask

        task check_result(logic [1:0] user, logic [23:0] data, logic last);
            token_result_t r;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected item kind %0d data %h last %b",
                                 user, data, last));
                return;
            end
            r = pending_results.pop_front();
            if (user !== r.kind)
                report($sformatf("result_kind %0d, want %0d", user, r.kind));
            if (data[7:0] !== r.tok)
                report($sformatf("token_byte %h, want %h", data[7:0], r.tok));
            if (data[11:8] !== r.idx)
                report($sformatf("arg_index %0d, want %0d", data[11:8], r.idx));
            if (data[16:12] !== r.cnt)
                report($sformatf("arg_count %0d, want %0d", data[16:12], r.cnt));
            if (data[23:17] !== 7'd0)
                report($sformatf("tdata padding %h not zero", data[23:17]));
            if (last !== r.last)
                report($sformatf("last_of_run %b, want %b", last, r.last));
        endtask

        task final_check();
            if (pending_results.size() != 0)
                report($sformatf("%0d expected items never arrived",
                                 pending_results.size()));
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] text_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [7:0] token_byte, [11:8] arg_index, [16:12] arg_count
    logic        m_tlast;
    logic [1:0]  m_tuser;   // [1:0] result_kind

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int hold_cycles   = 0;

    logic [7:0] text_q[$];

    tokenizer_scoreboard sb = new();

    command_line_tokenizer_unit #(
        .TOKEN_CHARS(TOKEN_CHARS),
        .MAX_ARGS   (MAX_ARGS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata, m_tlast);
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        sb.scan_text_byte(b);
        @(negedge aclk);
    endtask

    task automatic send_text();
        while (text_q.size() != 0)
            send_byte(text_q.pop_front());
        s_tvalid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (sb.pending_results.size() != 0)
            @(negedge aclk);
    endtask

    function automatic void push_str(string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endfunction

    function automatic logic [7:0] word_char(bit at_start);
        logic [7:0] c;
        do c = 8'($urandom_range(33, 255));
        while (at_start && (c == clt_pkg::QUOTE_CODE || c == clt_pkg::SLASH_CODE));
        return c;
    endfunction

    function automatic logic [7:0] sep_char();
        logic [7:0] c;
        if ($urandom_range(1) == 0)
            return clt_pkg::SPACE_CODE;
        do c = 8'($urandom_range(1, 32)); while (c == clt_pkg::NEWLINE_CODE);
        return c;
    endfunction

    function automatic logic [7:0] quoted_char();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == clt_pkg::QUOTE_CODE);
        return c;
    endfunction

    // flavor 1: long words and quotes around the token limit; 2: too many args
    function automatic void build_command(int flavor);
        int n_tok;
        int len;
        int pick;
        logic [7:0] c;
        if (flavor == 2)
            n_tok = 18;
        else if (flavor == 1)
            n_tok = 3;
        else if ($urandom_range(11) == 0)
            n_tok = $urandom_range(15, 19);
        else
            n_tok = $urandom_range(0, 5);
        for (int t = 0; t < n_tok; t++) begin
            text_q.push_back(sep_char());
            if ($urandom_range(3) == 0)
                text_q.push_back(sep_char());
            if (flavor == 1) begin
                pick = (t < 2) ? 0 : 5;
                len  = 31 + t;
            end else begin
                pick = (flavor == 2) ? $urandom_range(6) : $urandom_range(9);
                len  = (flavor == 0 && $urandom_range(4) == 0) ? $urandom_range(29, 40)
                                                               : $urandom_range(1, 3);
                if (flavor == 0 && len < 4)
                    len = $urandom_range(1, 6);
            end
            if (pick <= 4) begin
                text_q.push_back(word_char(1'b1));
                for (int i = 1; i < len; i++)
                    text_q.push_back(word_char(1'b0));
            end else if (pick <= 6) begin
                if (flavor == 0 && $urandom_range(3) == 0)
                    len = 0;
                text_q.push_back(clt_pkg::QUOTE_CODE);
                for (int i = 0; i < len; i++)
                    text_q.push_back(quoted_char());
                if (flavor != 0 || $urandom_range(9) != 0)
                    text_q.push_back(clt_pkg::QUOTE_CODE);
            end else if (pick == 7) begin
                text_q.push_back(clt_pkg::SLASH_CODE);
                text_q.push_back(clt_pkg::SLASH_CODE);
                repeat ($urandom_range(0, 4)) begin
                    do c = 8'($urandom_range(1, 255)); while (c == clt_pkg::NEWLINE_CODE);
                    text_q.push_back(c);
                end
                text_q.push_back(clt_pkg::NEWLINE_CODE);
            end else if (pick == 8) begin
                text_q.push_back(clt_pkg::SLASH_CODE);
                for (int i = 0; i < $urandom_range(0, 2); i++)
                    text_q.push_back(word_char(i == 0));
            end else begin
                text_q.push_back(8'($urandom_range(255)));
            end
        end
        if ($urandom_range(1) == 0)
            text_q.push_back(sep_char());
        text_q.push_back(($urandom_range(3) == 0) ? clt_pkg::NUL_CODE : clt_pkg::NEWLINE_CODE);
    endfunction

    task automatic run_phase(int src_pct, int snk_pct, int target);
        int sent;
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        sent = 0;
        while (sent < target) begin
            build_command(0);
            sent += text_q.size();
            send_text();
        end
        wait_drained();
    endtask

    initial begin
        s_tvalid = 1'b0;
        s_tdata  = 8'd0;
        aresetn  = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // high byte, quote inside a word, empty quotes, newline in quotes,
        // comment eating its line break, slash word, zero in comment and quotes
        text_q.push_back(8'hFF);
        push_str("!\" \"\"\"x\n\"//c\n\n\t/q\n//k");
        text_q.push_back(clt_pkg::NUL_CODE);
        push_str("\"w");
        text_q.push_back(clt_pkg::NUL_CODE);
        text_q.push_back(clt_pkg::NUL_CODE);
        push_str("/");
        text_q.push_back(clt_pkg::NUL_CODE);
        send_text();
        wait_drained();

        build_command(1);
        send_text();
        run_phase(0, 0, 10);

        // hold the sink off while a long command keeps the input busy
        @(posedge aclk);
        hold_cycles = 400;
        @(negedge aclk);
        build_command(2);
        send_text();
        wait_drained();

        run_phase(82, 0, 10);
        run_phase(0, 82, 10);
        run_phase(16, 16, 10);

        repeat (40) @(negedge aclk);
        sb.final_check();
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
